/* hw/rtl/mef_pkg.sv */
// ----------------------------------------------------------------------------
// mef_pkg
// Shared types and codes for the max-flow engine.
// ----------------------------------------------------------------------------
`default_nettype none
package mef_pkg;

    localparam int VCMP_W = 11;  // covers vertex numbers up to 1024

    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_RUN   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_RANGE = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ADD_A,
        ST_ADD_B,
        ST_LK_RD,
        ST_LK_WR,
        ST_CLR,
        ST_S_INIT,
        ST_S_POP,
        ST_S_CUR,
        ST_S_ADJ,
        ST_S_ERD,
        ST_S_EVAL,
        ST_T_RD,
        ST_T_PAR,
        ST_T_EVAL,
        ST_T_CHK,
        ST_P_RD,
        ST_P_PAR,
        ST_P_FWD,
        ST_P_RWR,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

/* hw/rtl/mef_ram.sv */
// ----------------------------------------------------------------------------
// mef_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none
module mef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* hw/rtl/max_flow_edmonds_karp.sv */
// ----------------------------------------------------------------------------
// max_flow_edmonds_karp
// Edge table loader and Edmonds-Karp max-flow sequencer over shared RAMs.
// ----------------------------------------------------------------------------
// Add: writes the two entries, then links each into its vertex list, then the result.
// Errors: result the cycle after start; clear: does not raise busy.
// Run: first clears the flow of every stored entry; each search then pops vertices
// and scans their lists for entries with residual capacity to unvisited vertices;
// each path found is traced back and its bottleneck pushed; no path ends the run.
// One item at a time while busy; results cannot be stalled.
// Reset empties all lists and sets num_vertices to 64; table RAMs hold garbage.
`default_nettype none
module max_flow_edmonds_karp
    import mef_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 256,
    parameter int CAP_WIDTH    = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_action,
    input  wire logic [5:0]  i_from_vertex,
    input  wire logic [5:0]  i_to_vertex,
    input  wire logic [31:0] i_capacity,
    input  wire logic [5:0]  i_source_vertex,
    input  wire logic [5:0]  i_sink_vertex,
    input  wire logic        i_cfg_we,
    input  wire logic [6:0]  i_cfg_wdata,
    output logic             o_valid,
    output logic [31:0]      o_max_flow,
    output logic             o_saturated,
    output logic [1:0]       o_error
);

    localparam int SLOTS = 2 * MAX_EDGES;
    localparam int EB    = $clog2(SLOTS);
    localparam int CNTW  = $clog2(SLOTS + 1);
    localparam int VB    = $clog2(MAX_VERTICES);
    localparam int QW    = $clog2(MAX_VERTICES + 1);
    localparam int FW    = CAP_WIDTH + 2;
    localparam int TW    = CAP_WIDTH + EB + 2;
    localparam int EW    = 2 * VB + CAP_WIDTH;

    function automatic logic [VCMP_W-1:0] ext6(input logic [5:0] v);
        ext6 = {{(VCMP_W-6){1'b0}}, v};
    endfunction

    function automatic logic [VB-1:0] vtrunc(input logic [5:0] v);
        logic [VCMP_W-1:0] w;
        w = ext6(v);
        vtrunc = w[VB-1:0];
    endfunction

    // state and registers
    t_state r_state, n_state;
    logic [6:0]              r_cfg;
    logic [CNTW-1:0]         r_count, n_count;
    logic [MAX_VERTICES-1:0] r_nonempty, n_nonempty;
    logic [MAX_VERTICES-1:0] r_visited, n_visited;
    logic [VB-1:0]           r_from, n_from, r_to, n_to, r_src, n_src, r_snk, n_snk;
    logic [CAP_WIDTH-1:0]    r_cap, n_cap;
    logic                    r_lk_sel, n_lk_sel;
    logic [CNTW-1:0]         r_idx, n_idx;
    logic [QW-1:0]           r_qh, n_qh, r_qt, n_qt;
    logic [EB-1:0]           r_e, n_e, r_etail, n_etail;
    logic [VB-1:0]           r_v, n_v;
    logic [VCMP_W-1:0]       r_steps, n_steps;
    logic signed [FW-1:0]    r_m, n_m;
    logic [TW-1:0]           r_total, n_total;
    logic                    r_valid, n_valid;
    logic [31:0]             r_flow_out, n_flow_out;
    logic                    r_sat, n_sat;
    logic [1:0]              r_err, n_err;

    // RAM ports
    logic                 ent_we;
    logic [EB-1:0]        ent_waddr, ent_raddr;
    logic [EW-1:0]        ent_wdata, ent_rdata;
    logic                 nxt_we;
    logic [EB-1:0]        nxt_waddr, nxt_raddr, nxt_wdata, nxt_rdata;
    logic                 flw_we;
    logic [EB-1:0]        flw_waddr, flw_raddr;
    logic [FW-1:0]        flw_wdata, flw_rdata;
    logic                 adj_we;
    logic [VB-1:0]        adj_waddr, adj_raddr;
    logic [2*EB-1:0]      adj_wdata, adj_rdata;
    logic                 par_we;
    logic [VB-1:0]        par_waddr, par_raddr;
    logic [EB-1:0]        par_wdata, par_rdata;
    logic                 q_we;
    logic [VB-1:0]        q_waddr, q_raddr;
    logic [VB-1:0]        q_wdata, q_rdata;

    mef_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_ent (
        .i_clk(i_clk), .i_we(ent_we), .i_waddr(ent_waddr), .i_wdata(ent_wdata),
        .i_raddr(ent_raddr), .o_rdata(ent_rdata));
    mef_ram #(.WIDTH(EB), .DEPTH(SLOTS)) u_nxt (
        .i_clk(i_clk), .i_we(nxt_we), .i_waddr(nxt_waddr), .i_wdata(nxt_wdata),
        .i_raddr(nxt_raddr), .o_rdata(nxt_rdata));
    mef_ram #(.WIDTH(FW), .DEPTH(SLOTS)) u_flw (
        .i_clk(i_clk), .i_we(flw_we), .i_waddr(flw_waddr), .i_wdata(flw_wdata),
        .i_raddr(flw_raddr), .o_rdata(flw_rdata));
    mef_ram #(.WIDTH(2*EB), .DEPTH(MAX_VERTICES)) u_adj (
        .i_clk(i_clk), .i_we(adj_we), .i_waddr(adj_waddr), .i_wdata(adj_wdata),
        .i_raddr(adj_raddr), .o_rdata(adj_rdata));
    mef_ram #(.WIDTH(EB), .DEPTH(MAX_VERTICES)) u_par (
        .i_clk(i_clk), .i_we(par_we), .i_waddr(par_waddr), .i_wdata(par_wdata),
        .i_raddr(par_raddr), .o_rdata(par_rdata));
    mef_ram #(.WIDTH(VB), .DEPTH(MAX_VERTICES)) u_q (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr(q_raddr), .o_rdata(q_rdata));

    // effective vertex count, clamped
    logic [VCMP_W-1:0] nv;
    always_comb begin
        nv = {{(VCMP_W-7){1'b0}}, r_cfg};
        if (nv < VCMP_W'(2)) begin
            nv = VCMP_W'(2);
        end else if (nv > VCMP_W'(MAX_VERTICES)) begin
            nv = VCMP_W'(MAX_VERTICES);
        end
    end

    // entry record fields
    logic [VB-1:0]        ent_tail, ent_head;
    logic [CAP_WIDTH-1:0] ent_cap;
    logic signed [FW-1:0] resid;
    logic [EB-1:0]        ent_a, ent_b, lk_entry;
    logic [VB-1:0]        lk_v;
    assign ent_tail = ent_rdata[EW-1 -: VB];
    assign ent_head = ent_rdata[CAP_WIDTH+VB-1 -: VB];
    assign ent_cap  = ent_rdata[CAP_WIDTH-1:0];
    assign resid    = $signed({2'b00, ent_cap}) - $signed(flw_rdata);
    assign ent_a    = r_count[EB-1:0];
    assign ent_b    = ent_a | EB'(1);
    assign lk_entry = r_lk_sel ? ent_b : ent_a;
    assign lk_v     = r_lk_sel ? r_to : r_from;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_nonempty = r_nonempty;
        n_visited  = r_visited;
        n_from     = r_from;
        n_to       = r_to;
        n_src      = r_src;
        n_snk      = r_snk;
        n_cap      = r_cap;
        n_lk_sel   = r_lk_sel;
        n_idx      = r_idx;
        n_qh       = r_qh;
        n_qt       = r_qt;
        n_e        = r_e;
        n_etail    = r_etail;
        n_v        = r_v;
        n_steps    = r_steps;
        n_m        = r_m;
        n_total    = r_total;
        n_valid    = 1'b0;
        n_flow_out = r_flow_out;
        n_sat      = r_sat;
        n_err      = r_err;

        ent_we = 1'b0; ent_waddr = ent_a; ent_wdata = {r_from, r_to, r_cap};
        ent_raddr = r_e;
        nxt_we = 1'b0; nxt_waddr = adj_rdata[EB-1:0]; nxt_wdata = lk_entry;
        nxt_raddr = r_e;
        flw_we = 1'b0; flw_waddr = ent_a; flw_wdata = '0; flw_raddr = r_e;
        adj_we = 1'b0; adj_waddr = lk_v; adj_wdata = {lk_entry, lk_entry};
        adj_raddr = lk_v;
        par_we = 1'b0; par_waddr = ent_head; par_wdata = r_e; par_raddr = r_v;
        q_we = 1'b0; q_waddr = r_qt[VB-1:0]; q_wdata = ent_head;
        q_raddr = r_qh[VB-1:0];

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_from = vtrunc(i_from_vertex);
                    n_to   = vtrunc(i_to_vertex);
                    n_cap  = CAP_WIDTH'(i_capacity);
                    n_src  = vtrunc(i_source_vertex);
                    n_snk  = vtrunc(i_sink_vertex);
                    n_flow_out = '0;
                    n_sat  = 1'b0;
                    n_err  = ERR_OK;
                    case (i_action)
                        ACT_ADD: begin
                            if (ext6(i_from_vertex) >= nv || ext6(i_to_vertex) >= nv) begin
                                n_err = ERR_RANGE; n_valid = 1'b1;
                            end else if ((CNTW+1)'(r_count) + (CNTW+1)'(2)
                                         > (CNTW+1)'(SLOTS)) begin
                                n_err = ERR_FULL; n_valid = 1'b1;
                            end else begin
                                n_state = ST_ADD_A;
                            end
                        end
                        ACT_RUN: begin
                            if (ext6(i_source_vertex) >= nv || ext6(i_sink_vertex) >= nv) begin
                                n_err = ERR_RANGE; n_valid = 1'b1;
                            end else begin
                                n_idx   = '0;
                                n_total = '0;
                                n_state = ST_CLR;
                            end
                        end
                        ACT_CLEAR: begin
                            n_count    = '0;
                            n_nonempty = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ADD_A: begin
                ent_we = 1'b1; flw_we = 1'b1;
                n_state = ST_ADD_B;
            end
            ST_ADD_B: begin
                ent_we = 1'b1; ent_waddr = ent_b; ent_wdata = {r_to, r_from, r_cap};
                flw_we = 1'b1; flw_waddr = ent_b;
                n_lk_sel = 1'b0;
                n_state  = ST_LK_RD;
            end
            ST_LK_RD: begin
                n_state = ST_LK_WR;
            end
            ST_LK_WR: begin
                adj_we = 1'b1;
                if (r_nonempty[lk_v]) begin
                    nxt_we    = 1'b1;
                    adj_wdata = {adj_rdata[2*EB-1:EB], lk_entry};
                end
                n_nonempty[lk_v] = 1'b1;
                if (!r_lk_sel) begin
                    n_lk_sel = 1'b1;
                    n_state  = ST_LK_RD;
                end else begin
                    n_count = r_count + CNTW'(2);
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_CLR: begin
                if (r_idx == r_count) begin
                    n_state = ST_S_INIT;
                end else begin
                    flw_we    = 1'b1;
                    flw_waddr = r_idx[EB-1:0];
                    n_idx     = r_idx + CNTW'(1);
                end
            end
            ST_S_INIT: begin
                n_visited = '0;
                n_visited[r_src] = 1'b1;
                q_we = 1'b1; q_waddr = '0; q_wdata = r_src;
                n_qh = '0;
                n_qt = QW'(1);
                n_state = ST_S_POP;
            end
            ST_S_POP: begin
                if (r_qh == r_qt) begin
                    n_state = ST_DONE;
                end else begin
                    n_qh    = r_qh + QW'(1);
                    n_state = ST_S_CUR;
                end
            end
            ST_S_CUR: begin
                adj_raddr = q_rdata;
                n_state = r_nonempty[q_rdata] ? ST_S_ADJ : ST_S_POP;
            end
            ST_S_ADJ: begin
                n_e     = adj_rdata[2*EB-1:EB];
                n_etail = adj_rdata[EB-1:0];
                n_state = ST_S_ERD;
            end
            ST_S_ERD: begin
                n_state = ST_S_EVAL;
            end
            ST_S_EVAL: begin
                n_state = (r_e == r_etail) ? ST_S_POP : ST_S_ERD;
                n_e     = nxt_rdata;
                if (VCMP_W'(ent_head) < nv && !r_visited[ent_head] &&
                    $signed({2'b00, ent_cap}) > $signed(flw_rdata)) begin
                    par_we = 1'b1;
                    n_visited[ent_head] = 1'b1;
                    if (r_qt < QW'(MAX_VERTICES)) begin
                        q_we = 1'b1;
                        n_qt = r_qt + QW'(1);
                    end
                    if (ent_head == r_snk) begin
                        n_v     = r_snk;
                        n_steps = '0;
                        n_m     = {1'b0, {(FW-1){1'b1}}};
                        n_state = ST_T_RD;
                    end
                end
            end
            ST_T_RD: begin
                n_state = (r_v == r_src || r_steps >= nv) ? ST_T_CHK : ST_T_PAR;
            end
            ST_T_PAR: begin
                n_e = par_rdata; ent_raddr = par_rdata; flw_raddr = par_rdata;
                n_state = ST_T_EVAL;
            end
            ST_T_EVAL: begin
                if (resid < r_m) begin
                    n_m = resid;
                end
                n_v     = ent_tail;
                n_steps = r_steps + VCMP_W'(1);
                n_state = ST_T_RD;
            end
            ST_T_CHK: begin
                if (r_m <= 0 || r_v != r_src) begin
                    n_state = ST_DONE;
                end else begin
                    n_v     = r_snk;
                    n_steps = '0;
                    n_state = ST_P_RD;
                end
            end
            ST_P_RD: begin
                if (r_v == r_src || r_steps >= nv) begin
                    n_total = r_total + TW'($unsigned(r_m));
                    n_state = ST_S_INIT;
                end else begin
                    n_state = ST_P_PAR;
                end
            end
            ST_P_PAR: begin
                n_e = par_rdata; ent_raddr = par_rdata; flw_raddr = par_rdata;
                n_state = ST_P_FWD;
            end
            ST_P_FWD: begin
                flw_we    = 1'b1;
                flw_waddr = r_e;
                flw_wdata = $signed(flw_rdata) + r_m;
                flw_raddr = r_e ^ EB'(1);
                n_v       = ent_tail;
                n_steps   = r_steps + VCMP_W'(1);
                n_state   = ST_P_RWR;
            end
            ST_P_RWR: begin
                flw_we    = 1'b1;
                flw_waddr = r_e ^ EB'(1);
                flw_wdata = $signed(flw_rdata) - r_m;
                n_state   = ST_P_RD;
            end
            ST_DONE: begin
                if (64'(r_total) > 64'hFFFF_FFFF) begin
                    n_flow_out = 32'hFFFF_FFFF;
                    n_sat      = 1'b1;
                end else begin
                    n_flow_out = 32'(r_total);
                end
                n_valid = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cfg      <= 7'd64;
            r_count    <= '0;
            r_nonempty <= '0;
            r_visited  <= '0;
            r_qh       <= '0;
            r_qt       <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            r_count    <= n_count;
            r_nonempty <= n_nonempty;
            r_visited  <= n_visited;
            r_qh       <= n_qh;
            r_qt       <= n_qt;
            r_valid    <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_from     <= n_from;
        r_to       <= n_to;
        r_src      <= n_src;
        r_snk      <= n_snk;
        r_cap      <= n_cap;
        r_lk_sel   <= n_lk_sel;
        r_idx      <= n_idx;
        r_e        <= n_e;
        r_etail    <= n_etail;
        r_v        <= n_v;
        r_steps    <= n_steps;
        r_m        <= n_m;
        r_total    <= n_total;
        r_flow_out <= n_flow_out;
        r_sat      <= n_sat;
        r_err      <= n_err;
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_valid     = r_valid;
    assign o_max_flow  = r_flow_out;
    assign o_saturated = r_sat;
    assign o_error     = r_err;

    // queue head never passes the tail
    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qh <= r_qt) else $error("queue head passed tail");

    // table holds whole edges only
    a_count_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_count[0] && r_count <= CNTW'(SLOTS)) else $error("bad edge count");

    // a result follows an accepted item or the end of a busy stretch
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(busy) || $past(start)) else $error("result without item");

    // the source stays visited while a search scans entries
    a_src_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_S_EVAL) |-> r_visited[r_src]) else $error("source not visited");

endmodule
`default_nettype wire
